>>> src/i2c_master_transaction_sequencer_unit_assert.svh
// Assertion macros for the I2C master transaction sequencer.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ims assertion failed");

// Next-cycle implication, disabled during reset.
`define IMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ims assertion failed");

`endif

>>> src/ims_pkg.sv
// Types and constants of the I2C master transaction sequencer.
package ims_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WSTART = 3'd1,
        PH_WADDR  = 3'd2,
        PH_WDATA  = 3'd3,
        PH_RSTART = 3'd4,
        PH_RADDR  = 3'd5,
        PH_RACK   = 3'd6,
        PH_RNACK  = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_START  = 3'd1,
        CMD_SEND   = 3'd2,
        CMD_RXACK  = 3'd3,
        CMD_RXNACK = 3'd4,
        CMD_STOP   = 3'd5
    } t_cmd;

    localparam logic [7:0] STATUS_MASK   = 8'hf8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_WADDR_ACK  = 8'h18;
    localparam logic [7:0] ST_WADDR_NAK  = 8'h20;
    localparam logic [7:0] ST_WDATA_ACK  = 8'h28;
    localparam logic [7:0] ST_WDATA_NAK  = 8'h30;
    localparam logic [7:0] ST_RADDR_ACK  = 8'h40;
    localparam logic [7:0] ST_RADDR_NAK  = 8'h48;
    localparam logic [7:0] ST_RDATA_ACK  = 8'h50;
    localparam logic [7:0] ST_RDATA_NAK  = 8'h58;
    localparam logic [7:0] ADDR_WR_MASK  = 8'hfe;
    localparam logic       FUNC_START    = 1'b0;

    typedef struct packed {
        logic        func;
        logic [7:0]  slave_addr;
        logic [15:0] write_count;
        logic [15:0] read_count;
        logic [7:0]  bus_status;
        logic [7:0]  rx_byte;
        logic [7:0]  tx_byte;
    } t_item;

    // Declared high to low so command lands in the lowest bits.
    typedef struct packed {
        logic [7:0] result_status;
        logic       done_res;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic [7:0] tx_data;
        t_cmd       command;
    } t_res;

    localparam int DATA_W = $bits(t_cmd) + 24;
    localparam int OUT_W  = ((DATA_W + 7) / 8) * 8;

endpackage

>>> src/ims_core.sv
// Transaction state and combinational next-command logic.
module ims_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  ims_pkg::t_item i_item,
    output ims_pkg::t_res  o_res,
    output ims_pkg::t_phase o_phase
);
    import ims_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_writes_left, n_writes_left;
    logic [15:0] r_reads_left, n_reads_left;
    logic [7:0]  r_target_addr, n_target_addr;
    logic        r_did_write, n_did_write;

    logic [7:0]  s;
    logic [15:0] rd_dec;
    t_res        res;

    assign s      = i_item.bus_status & STATUS_MASK;
    assign rd_dec = (r_reads_left != 16'd0) ? (r_reads_left - 16'd1) : r_reads_left;

    always_comb begin
        res           = '0;
        n_phase       = r_phase;
        n_writes_left = r_writes_left;
        n_reads_left  = r_reads_left;
        n_target_addr = r_target_addr;
        n_did_write   = r_did_write;
        if (i_item.func == FUNC_START) begin
            if (r_phase == PH_IDLE) begin
                n_target_addr = i_item.slave_addr;
                n_writes_left = i_item.write_count;
                n_reads_left  = i_item.read_count;
                if (i_item.write_count != 16'd0) begin
                    n_did_write = 1'b1;
                    res.command = CMD_START;
                    n_phase     = PH_WSTART;
                end else if (i_item.read_count != 16'd0) begin
                    n_did_write = 1'b0;
                    res.command = CMD_START;
                    n_phase     = PH_RSTART;
                end else begin
                    n_did_write  = 1'b0;
                    res.done_res = 1'b1;
                    n_phase      = PH_IDLE;
                end
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_WSTART: begin
                    if (s != ST_START) begin
                        res.done_res      = 1'b1;
                        res.result_status = s;
                        n_phase           = PH_IDLE;
                    end else begin
                        res.command = CMD_SEND;
                        res.tx_data = r_target_addr & ADDR_WR_MASK;
                        n_phase     = PH_WADDR;
                    end
                end
                PH_WADDR, PH_WDATA: begin
                    if (s != ((r_phase == PH_WADDR) ? ST_WADDR_ACK : ST_WDATA_ACK)) begin
                        res.command = (s == ((r_phase == PH_WADDR) ? ST_WADDR_NAK
                                                                    : ST_WDATA_NAK))
                                      ? CMD_STOP : CMD_NONE;
                        res.done_res      = 1'b1;
                        res.result_status = s;
                        n_phase           = PH_IDLE;
                    end else if (r_writes_left != 16'd0) begin
                        n_writes_left = r_writes_left - 16'd1;
                        res.command   = CMD_SEND;
                        res.tx_data   = i_item.tx_byte;
                        n_phase       = PH_WDATA;
                    end else if (r_reads_left != 16'd0) begin
                        res.command = CMD_START;
                        n_phase     = PH_RSTART;
                    end else begin
                        res.command  = CMD_STOP;
                        res.done_res = 1'b1;
                        n_phase      = PH_IDLE;
                    end
                end
                PH_RSTART: begin
                    if (s != (r_did_write ? ST_RSTART : ST_START)) begin
                        res.done_res      = 1'b1;
                        res.result_status = s;
                        n_phase           = PH_IDLE;
                    end else begin
                        res.command = CMD_SEND;
                        res.tx_data = r_target_addr | 8'h01;
                        n_phase     = PH_RADDR;
                    end
                end
                PH_RADDR: begin
                    if (s != ST_RADDR_ACK) begin
                        res.command       = (s == ST_RADDR_NAK) ? CMD_STOP : CMD_NONE;
                        res.done_res      = 1'b1;
                        res.result_status = s;
                        n_phase           = PH_IDLE;
                    end else if (r_reads_left > 16'd1) begin
                        res.command = CMD_RXACK;
                        n_phase     = PH_RACK;
                    end else begin
                        res.command = CMD_RXNACK;
                        n_phase     = PH_RNACK;
                    end
                end
                PH_RACK: begin
                    if (s != ST_RDATA_ACK) begin
                        res.done_res      = 1'b1;
                        res.result_status = s;
                        n_phase           = PH_IDLE;
                    end else begin
                        res.rx_valid = 1'b1;
                        res.rx_data  = i_item.rx_byte;
                        n_reads_left = rd_dec;
                        if (rd_dec > 16'd1) begin
                            res.command = CMD_RXACK;
                        end else begin
                            res.command = CMD_RXNACK;
                            n_phase     = PH_RNACK;
                        end
                    end
                end
                PH_RNACK: begin
                    if (s != ST_RDATA_NAK) begin
                        res.done_res      = 1'b1;
                        res.result_status = s;
                        n_phase           = PH_IDLE;
                    end else begin
                        res.rx_valid = 1'b1;
                        res.rx_data  = i_item.rx_byte;
                        n_reads_left = 16'd0;
                        res.command  = CMD_STOP;
                        res.done_res = 1'b1;
                        n_phase      = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_writes_left <= 16'd0;
            r_reads_left  <= 16'd0;
            r_target_addr <= 8'd0;
            r_did_write   <= 1'b0;
        end else if (i_adv) begin
            r_phase       <= n_phase;
            r_writes_left <= n_writes_left;
            r_reads_left  <= n_reads_left;
            r_target_addr <= n_target_addr;
            r_did_write   <= n_did_write;
        end
    end

    assign o_res   = res;
    assign o_phase = r_phase;

endmodule

>>> src/i2c_master_transaction_sequencer_unit.sv
// Top level of the I2C master transaction sequencer: input register, core, result register.
// One word in gives one word out, and a word can be taken on every cycle while the output
// is not stalled. Each word passes through the input register, then the result register; a
// stalled result holds the input register, and the input side stops once both registers are
// full. Input tuser carries func (0 start request, 1 bus event). Output tdata carries
// command (0 none, 1 start, 2 send, 3 receive with ACK, 4 receive with NACK, 5 stop),
// tx_data, rx_data and result_status (the masked status of a failure); output tuser flags a
// delivered read byte and tlast marks the word that ends a transaction.
`include "i2c_master_transaction_sequencer_unit_assert.svh"

module i2c_master_transaction_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // slave_addr[7:0], write_count[23:8], read_count[39:24], bus_status[47:40],
    // rx_byte[55:48], tx_byte[63:56]
    input  logic [63:0] i_s_tdata,
    // func[0]
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // command[2:0], tx_data[10:3], rx_data[18:11], result_status[26:19], zero[31:27]
    output logic [ims_pkg::OUT_W-1:0] o_m_tdata,
    // rx_valid[0]
    output logic        o_m_tuser,
    output logic        o_m_tlast
);
    import ims_pkg::*;

    logic   r_in_valid;
    t_item  r_in;
    logic   r_out_valid;
    t_res   r_out;
    logic   adv;
    t_res   res;
    t_phase phase;
    logic   rx_cmd_ok;

    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.func        <= i_s_tuser;
            r_in.slave_addr  <= i_s_tdata[7:0];
            r_in.write_count <= i_s_tdata[23:8];
            r_in.read_count  <= i_s_tdata[39:24];
            r_in.bus_status  <= i_s_tdata[47:40];
            r_in.rx_byte     <= i_s_tdata[55:48];
            r_in.tx_byte     <= i_s_tdata[63:56];
        end
    end

    ims_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .o_res   (res),
        .o_phase (phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W - DATA_W){1'b0}}, r_out.result_status, r_out.rx_data,
                         r_out.tx_data, r_out.command};
    assign o_m_tuser  = r_out.rx_valid;
    assign o_m_tlast  = r_out.done_res;

    assign rx_cmd_ok = (r_out.command == CMD_RXACK) || (r_out.command == CMD_RXNACK) ||
                       (r_out.command == CMD_STOP);

    `IMS_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_out_valid && r_out.done_res, phase == PH_IDLE)
    `IMS_ASSERT_NOW(a_rx_cmd, i_clk, i_rst_n, r_out_valid && r_out.rx_valid, rx_cmd_ok)
    `IMS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid)

endmodule
